FILE: sv/lrfp_pkg.sv
// ----------------------------------------------------------------------------
// lrfp_pkg
// Shared types and constants for the laser range frame parser.
// ----------------------------------------------------------------------------
package lrfp_pkg;

  // Default sizing
  localparam int FRAME_LEN_DEF    = 11;
  localparam int NUM_CHANNELS_DEF = 2;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 4;
  localparam int DIST_W  = 23;

  // Byte slots kept per channel: bytes 3 to 10 of a frame
  localparam int FIRST_SLOT = 3;
  localparam int LAST_SLOT  = 10;
  localparam int NUM_SLOTS  = LAST_SLOT - FIRST_SLOT + 1;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);

  // Frame bytes
  localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'h80;
  localparam logic [BYTE_W-1:0] HDR1_BYTE   = 8'h06;
  localparam logic [BYTE_W-1:0] HDR2_BYTE   = 8'h83;
  localparam logic [BYTE_W-1:0] FILL_BYTE   = 8'h2E;
  localparam logic [BYTE_W-1:0] MODE_LIMIT  = 8'h34;
  localparam logic [BYTE_W-1:0] ERR_CHAR    = 8'h45;  // 'E'
  localparam logic [BYTE_W-1:0] RANGE_CHAR  = 8'h52;  // 'R'
  localparam logic [BYTE_W-1:0] ZERO_CHAR   = 8'h30;  // '0'

  // Queue
  localparam int QUEUE_DEPTH = 2;

  // Completed frame handed from front to back
  typedef struct packed {
    logic              ch;
    logic [BYTE_W-1:0] b3;
    logic [BYTE_W-1:0] b4;
    logic [BYTE_W-1:0] b5;
    logic [BYTE_W-1:0] b7;
    logic [BYTE_W-1:0] b8;
    logic [BYTE_W-1:0] b9;
    logic [BYTE_W-1:0] b10;
  } frame_t;

endpackage

FILE: sv/laser_range_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// laser_range_frame_parser_unit
// Parses rangefinder frames from interleaved serial byte channels.
// ----------------------------------------------------------------------------
// Input channel: one request per received byte (in_channel, in_rx_byte),
// taken when in_valid is high and in_stall is low. Bytes of each channel
// are gathered into a frame of FRAME_LEN bytes; bytes for a channel number
// at or above NUM_CHANNELS are dropped.
// Result channel: one request per accepted frame (out_src_channel,
// out_distance), taken when out_valid is high and out_stall is low.
// Rejected frames give no request.
// Throughput: one byte per cycle while in_stall is low. The front counts
// and captures bytes, a two-entry frame queue decouples it from the back,
// which checks the frame and holds the result in an output register.
// A taken final byte puts its frame in the queue, then the result register.
// Stalling: while out_stall holds, finished frames fill the queue; in_stall
// rises only when the queue is full.
// Reset clears all byte counts, the queue and the result valid flag; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module laser_range_frame_parser_unit #(
  parameter int FRAME_LEN    = lrfp_pkg::FRAME_LEN_DEF,
  parameter int NUM_CHANNELS = lrfp_pkg::NUM_CHANNELS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_channel,
  input  logic [lrfp_pkg::BYTE_W-1:0]         in_rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_src_channel,
  output logic signed [lrfp_pkg::DIST_W-1:0]  out_distance
);

  logic             q_full;
  logic             push;
  lrfp_pkg::frame_t push_frame;
  logic             pop;
  logic             head_valid;
  lrfp_pkg::frame_t head_frame;

  assign in_stall = q_full;

  // Byte intake and frame capture
  lrfp_front #(
    .FRAME_LEN    (FRAME_LEN),
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_channel (in_channel),
    .in_rx_byte (in_rx_byte),
    .q_full     (q_full),
    .push       (push),
    .push_frame (push_frame)
  );

  // Frame queue
  lrfp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_frame (head_frame)
  );

  // Validation and result
  lrfp_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_frame      (head_frame),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_src_channel (out_src_channel),
    .out_distance    (out_distance)
  );

endmodule

FILE: sv/lrfp_front.sv
// ----------------------------------------------------------------------------
// lrfp_front
// Per-channel byte counting, header checking and frame capture.
// ----------------------------------------------------------------------------
module lrfp_front #(
  parameter int FRAME_LEN    = lrfp_pkg::FRAME_LEN_DEF,
  parameter int NUM_CHANNELS = lrfp_pkg::NUM_CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_channel,
  input  logic [lrfp_pkg::BYTE_W-1:0] in_rx_byte,
  input  logic                        q_full,
  output logic                        push,
  output lrfp_pkg::frame_t            push_frame
);

  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam logic [lrfp_pkg::CNT_W-1:0] LAST_CNT = lrfp_pkg::CNT_W'(FRAME_LEN - 1);
  localparam logic [lrfp_pkg::CNT_W-1:0] FIRST_CNT =
    lrfp_pkg::CNT_W'(lrfp_pkg::FIRST_SLOT);
  localparam logic [lrfp_pkg::CNT_W-1:0] LASTSLOT_CNT =
    lrfp_pkg::CNT_W'(lrfp_pkg::LAST_SLOT);

  logic [lrfp_pkg::CNT_W-1:0]  cnt_r  [NUM_CHANNELS];
  logic                        hdr1_r [NUM_CHANNELS];
  logic [lrfp_pkg::BYTE_W-1:0] slot_r [NUM_CHANNELS][lrfp_pkg::NUM_SLOTS];

  logic [CH_W-1:0]             ch_idx;
  logic                        ch_ok;
  logic                        acc;
  logic [lrfp_pkg::CNT_W-1:0]  cnt;
  logic [lrfp_pkg::CNT_W-1:0]  cnt_nxt;
  logic [lrfp_pkg::CNT_W-1:0]  slot_off;
  logic                        slot_wr;
  logic                        last_byte;

  assign ch_idx = CH_W'(in_channel);
  assign ch_ok  = (int'(in_channel) < NUM_CHANNELS);
  assign acc    = in_valid && !q_full && ch_ok;
  assign cnt    = cnt_r[ch_idx];

  // Count sequencing: sync byte, header bytes, then body
  always_comb begin
    cnt_nxt   = cnt + 1'b1;
    last_byte = 1'b0;
    if (cnt == '0) begin
      if (in_rx_byte != lrfp_pkg::SYNC_BYTE) cnt_nxt = '0;
    end else if (cnt == lrfp_pkg::CNT_W'(2)) begin
      if (!hdr1_r[ch_idx] || in_rx_byte != lrfp_pkg::HDR2_BYTE) cnt_nxt = '0;
    end else if (cnt >= LAST_CNT) begin
      cnt_nxt   = '0;
      last_byte = (cnt >= FIRST_CNT);
    end
  end

  assign slot_off = cnt - FIRST_CNT;
  assign slot_wr  = (cnt >= FIRST_CNT) && (cnt <= LASTSLOT_CNT);

  // Count and header flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) cnt_r[i] <= '0;
    end else if (acc) begin
      cnt_r[ch_idx] <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && cnt == 4'd1) hdr1_r[ch_idx] <= (in_rx_byte == lrfp_pkg::HDR1_BYTE);
  end

  // Body byte capture
  always_ff @(posedge clk) begin
    if (acc && slot_wr) slot_r[ch_idx][slot_off[lrfp_pkg::SLOT_W-1:0]] <= in_rx_byte;
  end

  // Frame request out; the final byte may still be on the input
  assign push = acc && last_byte;

  always_comb begin
    push_frame.ch  = in_channel;
    push_frame.b3  = slot_r[ch_idx][0];
    push_frame.b4  = slot_r[ch_idx][1];
    push_frame.b5  = slot_r[ch_idx][2];
    push_frame.b7  = slot_r[ch_idx][4];
    push_frame.b8  = slot_r[ch_idx][5];
    push_frame.b9  = slot_r[ch_idx][6];
    push_frame.b10 = (cnt == LASTSLOT_CNT) ? in_rx_byte : slot_r[ch_idx][7];
  end

endmodule

FILE: sv/lrfp_queue.sv
// ----------------------------------------------------------------------------
// lrfp_queue
// Small register queue of completed frames between front and back.
// ----------------------------------------------------------------------------
module lrfp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lrfp_pkg::frame_t push_frame,
  input  logic             pop,
  output logic             full,
  output logic             head_valid,
  output lrfp_pkg::frame_t head_frame
);

  localparam int PTR_W = (lrfp_pkg::QUEUE_DEPTH > 1) ? $clog2(lrfp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(lrfp_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(lrfp_pkg::QUEUE_DEPTH - 1);

  lrfp_pkg::frame_t  entry_r [lrfp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign full       = (fill_r == CNT_W'(lrfp_pkg::QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_frame = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    if (do_push && !do_pop) fill_nxt = fill_r + 1'b1;
    else if (!do_push && do_pop) fill_nxt = fill_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_frame;
  end

endmodule

FILE: sv/lrfp_back.sv
// ----------------------------------------------------------------------------
// lrfp_back
// Frame validation, distance assembly and the result register.
// ----------------------------------------------------------------------------
module lrfp_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        head_valid,
  input  lrfp_pkg::frame_t            head_frame,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_src_channel,
  output logic signed [lrfp_pkg::DIST_W-1:0] out_distance
);

  localparam int DW = lrfp_pkg::DIST_W;
  localparam logic [lrfp_pkg::BYTE_W-1:0] HDR_SUM =
    lrfp_pkg::SYNC_BYTE + lrfp_pkg::HDR1_BYTE + lrfp_pkg::HDR2_BYTE + lrfp_pkg::FILL_BYTE;

  logic                        out_valid_r;
  logic                        src_ch_r;
  logic signed [DW-1:0]        dist_r;
  logic [lrfp_pkg::BYTE_W-1:0] sum8;
  logic [lrfp_pkg::BYTE_W-1:0] check;
  logic                        frame_ok;
  logic signed [DW-1:0]        d4, d5, d7, d8, d9;
  logic signed [DW-1:0]        dist_sum;
  logic                        take;

  // Digit value of an ASCII byte, no range check
  function automatic logic signed [DW-1:0] digit(input logic [lrfp_pkg::BYTE_W-1:0] b);
    digit = $signed(DW'(b)) - $signed(DW'(lrfp_pkg::ZERO_CHAR));
  endfunction

  // Checksum and field checks
  always_comb begin
    sum8 = HDR_SUM + head_frame.b3 + head_frame.b4 + head_frame.b5
         + head_frame.b7 + head_frame.b8 + head_frame.b9;
    check    = 8'h00 - sum8;
    frame_ok = (head_frame.b3 != lrfp_pkg::ERR_CHAR) &&
               (head_frame.b3 <  lrfp_pkg::MODE_LIMIT) &&
               (head_frame.b4 != lrfp_pkg::RANGE_CHAR) &&
               (head_frame.b5 != lrfp_pkg::RANGE_CHAR) &&
               (head_frame.b10 == check);
  end

  // Weighted digit sum, wraps in the result width
  always_comb begin
    d4       = digit(head_frame.b4);
    d5       = digit(head_frame.b5);
    d7       = digit(head_frame.b7);
    d8       = digit(head_frame.b8);
    d9       = digit(head_frame.b9);
    dist_sum = DW'(d4 * $signed(DW'(10000))) + DW'(d5 * $signed(DW'(1000)))
             + DW'(d7 * $signed(DW'(100))) + DW'(d8 * $signed(DW'(10))) + d9;
  end

  // Result register: refills while the held request is being taken
  assign take = out_valid_r && !out_stall;
  assign pop  = head_valid && (!out_valid_r || take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop && frame_ok) begin
      out_valid_r <= 1'b1;
    end else if (take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && frame_ok) begin
      src_ch_r <= head_frame.ch;
      dist_r   <= dist_sum;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_src_channel = src_ch_r;
  assign out_distance    = dist_r;

endmodule

FILE: tb/tb_laser_range_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_laser_range_frame_parser_unit
// Self-checking bench for the two-channel laser range frame parser.
// ----------------------------------------------------------------------------
// Byte requests from both receivers go in interleaved. An internal copy of
// the per-channel frame gatherer predicts every accepted range, and each
// result request is checked against the oldest prediction. A short set of
// hand-built frames is followed by random traffic: mostly well-formed frames
// with random content, the rest broken frames and line noise, run with
// and without random gaps on the sending side and stalls on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_laser_range_frame_parser_unit;

  localparam int FLEN       = lrfp_pkg::FRAME_LEN_DEF;
  localparam int NCH        = lrfp_pkg::NUM_CHANNELS_DEF;
  localparam int QUIET_MAX  = 400;

  localparam int BYTE_W = lrfp_pkg::BYTE_W;
  localparam int DIST_W = lrfp_pkg::DIST_W;

  localparam logic [BYTE_W-1:0] SYNC_BYTE  = lrfp_pkg::SYNC_BYTE;
  localparam logic [BYTE_W-1:0] HDR1_BYTE  = lrfp_pkg::HDR1_BYTE;
  localparam logic [BYTE_W-1:0] HDR2_BYTE  = lrfp_pkg::HDR2_BYTE;
  localparam logic [BYTE_W-1:0] FILL_BYTE  = lrfp_pkg::FILL_BYTE;
  localparam logic [BYTE_W-1:0] MODE_LIMIT = lrfp_pkg::MODE_LIMIT;
  localparam logic [BYTE_W-1:0] ERR_CHAR   = lrfp_pkg::ERR_CHAR;
  localparam logic [BYTE_W-1:0] RANGE_CHAR = lrfp_pkg::RANGE_CHAR;
  localparam logic [BYTE_W-1:0] ZERO_CHAR  = lrfp_pkg::ZERO_CHAR;

  // Kinds of byte sequence offered on one channel
  typedef enum int {
    FRM_GOOD,
    FRM_ERROR_CHAR,
    FRM_MODE_HIGH,
    FRM_RANGE_B4,
    FRM_RANGE_B5,
    FRM_BAD_CHECK,
    FRM_BAD_SYNC,
    FRM_BAD_HDR1,
    FRM_BAD_HDR2,
    FRM_SHORT,
    FRM_NOISE
  } frame_kind_e;

  typedef struct {
    logic                     ch;
    logic signed [DIST_W-1:0] distance;
  } range_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_channel;
  logic [BYTE_W-1:0]        in_rx_byte;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_src_channel;
  logic signed [DIST_W-1:0] out_distance;

  // Predictor state
  logic [BYTE_W-1:0] frame_bytes [NCH][FLEN];
  int                frame_fill  [NCH];
  range_t            pending_ranges [$];

  // Bytes waiting to go out, per channel
  logic [BYTE_W-1:0] tx_bytes [NCH][$];

  bit src_idle;
  bit sink_idle;
  int sink_hold;
  int mismatches;
  int bytes_sent;
  int ranges_checked;
  int drains;

  laser_range_frame_parser_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_channel      (in_channel),
    .in_rx_byte      (in_rx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_src_channel (out_src_channel),
    .out_distance    (out_distance)
  );

  always #4 clk = ~clk;

  // Checksum byte: negated low byte of the sum of the header, bytes 3-5, fill and 7-9
  function automatic logic [BYTE_W-1:0] frame_check(input logic [BYTE_W-1:0] b3, b4, b5,
                                                    b7, b8, b9);
    logic [BYTE_W-1:0] sum;
    sum = SYNC_BYTE + HDR1_BYTE + HDR2_BYTE + b3 + b4 + b5 + FILL_BYTE + b7 + b8 + b9;
    return 8'd0 - sum;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Track one accepted byte; queue a range when it completes a good frame
  task automatic predict_byte(input logic ch, input logic [BYTE_W-1:0] b);
    int  pos;
    int  d;
    bit  ok;
    range_t r;
    pos = frame_fill[ch];
    if (pos >= FLEN) pos = 0;
    frame_bytes[ch][pos] = b;
    pos++;
    if (frame_bytes[ch][0] != SYNC_BYTE) begin
      frame_fill[ch] = 0;
    end else if (pos > 2 && (frame_bytes[ch][1] != HDR1_BYTE ||
                             frame_bytes[ch][2] != HDR2_BYTE)) begin
      frame_fill[ch] = 0;
    end else if (pos >= FLEN) begin
      frame_fill[ch] = 0;
      ok = frame_bytes[ch][3] != ERR_CHAR && frame_bytes[ch][3] < MODE_LIMIT &&
           frame_bytes[ch][4] != RANGE_CHAR && frame_bytes[ch][5] != RANGE_CHAR &&
           frame_bytes[ch][10] == frame_check(frame_bytes[ch][3], frame_bytes[ch][4],
                                              frame_bytes[ch][5], frame_bytes[ch][7],
                                              frame_bytes[ch][8], frame_bytes[ch][9]);
      if (ok) begin
        d = (int'(frame_bytes[ch][4]) - int'(ZERO_CHAR)) * 10000
          + (int'(frame_bytes[ch][5]) - int'(ZERO_CHAR)) * 1000
          + (int'(frame_bytes[ch][7]) - int'(ZERO_CHAR)) * 100
          + (int'(frame_bytes[ch][8]) - int'(ZERO_CHAR)) * 10
          + (int'(frame_bytes[ch][9]) - int'(ZERO_CHAR));
        r.ch       = ch;
        r.distance = d[DIST_W-1:0];
        pending_ranges.push_back(r);
      end
    end else begin
      frame_fill[ch] = pos;
    end
  endtask

  // Offer one byte request, after a random gap when enabled
  task automatic send_byte(input logic ch, input logic [BYTE_W-1:0] b);
    int gap;
    gap = src_idle ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_channel <= ch;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(ch, b);
    bytes_sent++;
  endtask

  // Hold off the sender until every predicted range has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    drains++;
  endtask

  // Hand-built frame bytes for one channel, checksum filled in
  task automatic push_frame(input logic ch, input logic [BYTE_W-1:0] b3, b4, b5, b6,
                            b7, b8, b9);
    tx_bytes[ch] = {tx_bytes[ch], SYNC_BYTE, HDR1_BYTE, HDR2_BYTE, b3, b4, b5, b6,
                    b7, b8, b9, frame_check(b3, b4, b5, b7, b8, b9)};
  endtask

  function automatic logic [BYTE_W-1:0] rand_digit();
    if ($urandom_range(0, 9) < 8) return ZERO_CHAR + BYTE_W'($urandom_range(0, 9));
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Queue one random sequence: usually a good frame, else a broken one or noise
  task automatic queue_sequence(input logic ch);
    frame_kind_e       kind;
    logic [BYTE_W-1:0] f [FLEN];
    int                n;
    if ($urandom_range(0, 99) < 55) kind = FRM_GOOD;
    else kind = frame_kind_e'($urandom_range(FRM_ERROR_CHAR, FRM_NOISE));
    if (kind == FRM_NOISE) begin
      n = $urandom_range(1, 6);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) tx_bytes[ch].push_back(SYNC_BYTE);
        else tx_bytes[ch].push_back(BYTE_W'($urandom_range(0, 255)));
      end
    end else begin
      f[0] = SYNC_BYTE;
      f[1] = HDR1_BYTE;
      f[2] = HDR2_BYTE;
      f[3] = BYTE_W'($urandom_range(0, MODE_LIMIT - 1));
      f[4] = rand_digit();
      f[5] = rand_digit();
      f[6] = BYTE_W'($urandom_range(0, 255));
      f[7] = rand_digit();
      f[8] = rand_digit();
      f[9] = rand_digit();
      n = FLEN;
      case (kind)
        FRM_ERROR_CHAR: f[3] = ERR_CHAR;
        FRM_MODE_HIGH:  f[3] = BYTE_W'($urandom_range(MODE_LIMIT, 255));
        FRM_RANGE_B4:   f[4] = RANGE_CHAR;
        FRM_RANGE_B5:   f[5] = RANGE_CHAR;
        FRM_BAD_SYNC:   f[0] = SYNC_BYTE ^ BYTE_W'($urandom_range(1, 255));
        FRM_BAD_HDR1:   f[1] = HDR1_BYTE ^ BYTE_W'($urandom_range(1, 255));
        FRM_BAD_HDR2:   f[2] = HDR2_BYTE ^ BYTE_W'($urandom_range(1, 255));
        FRM_SHORT:      n = $urandom_range(1, FLEN - 1);
        default: ;
      endcase
      f[10] = frame_check(f[3], f[4], f[5], f[7], f[8], f[9]);
      if (kind == FRM_BAD_CHECK) f[10] = f[10] ^ BYTE_W'($urandom_range(1, 255));
      for (int i = 0; i < n; i++) tx_bytes[ch].push_back(f[i]);
    end
  endtask

  // Random interleaved traffic on both channels
  task automatic run_traffic(input int n_bytes, input bit drain_pauses);
    int   sent;
    logic ch;
    sent = 0;
    while (sent < n_bytes) begin
      for (int c = 0; c < NCH; c++)
        if (tx_bytes[c].size() == 0) queue_sequence(1'(c));
      ch = 1'($urandom_range(0, NCH - 1));
      send_byte(ch, tx_bytes[ch].pop_front());
      sent++;
      if (drain_pauses && sent % 97 == 0) wait_drained();
    end
  endtask

  // Extremes: top and bottom distance, byte 3 at both ends of its range,
  // byte 6 at 0x00 and 0xFF, both channels interleaved, then a bad header
  task automatic test_directed_frames();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    push_frame(1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_frame(1'b1, MODE_LIMIT - 8'd1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    for (int i = 0; i < FLEN; i++) begin
      send_byte(1'b0, tx_bytes[0].pop_front());
      send_byte(1'b1, tx_bytes[1].pop_front());
    end
    send_byte(1'b0, SYNC_BYTE);
    send_byte(1'b0, HDR1_BYTE);
    send_byte(1'b0, HDR2_BYTE ^ 8'h01);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_traffic(300, 1'b0);
  endtask

  task automatic test_sender_gaps();
    src_idle  = 1'b1;
    sink_idle = 1'b0;
    run_traffic(300, 1'b0);
  endtask

  task automatic test_receiver_stalls();
    src_idle  = 1'b0;
    sink_idle = 1'b1;
    run_traffic(300, 1'b0);
  endtask

  task automatic test_mixed_idling();
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    run_traffic(350, 1'b1);
  endtask

  // Result side: check each request, then draw a stall for the next
  always @(posedge clk) begin
    range_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      sink_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_ranges.size() == 0) begin
          report_mismatch($sformatf("unexpected range ch=%0d distance=%0d",
                                    out_src_channel, out_distance));
        end else begin
          want = pending_ranges.pop_front();
          if (out_src_channel !== want.ch)
            report_mismatch($sformatf("src_channel %0d, expected %0d",
                                      out_src_channel, want.ch));
          if (out_distance !== want.distance)
            report_mismatch($sformatf("distance %0d, expected %0d ch=%0d",
                                      out_distance, want.distance, want.ch));
          ranges_checked++;
        end
        sink_hold = sink_idle ? $urandom_range(0, 4) : 0;
      end else if (sink_hold > 0) begin
        sink_hold--;
      end
      out_stall <= (sink_hold > 0);
    end
  end

  // Watchdog: too long with no request taken on either side
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_MAX) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no requests for %0d cycles", QUIET_MAX);
    $display("tb_laser_range_frame_parser_unit NOT OK");
    $finish;
  end

  initial begin
    mismatches     = 0;
    bytes_sent     = 0;
    ranges_checked = 0;
    drains         = 0;
    src_idle       = 1'b0;
    sink_idle      = 1'b0;
    for (int c = 0; c < NCH; c++) frame_fill[c] = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_channel <= 1'b0;
    in_rx_byte <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();

    wait_drained();
    repeat (8) @(posedge clk);
    $display("covered %0d bytes on %0d channels, %0d ranges checked, %0d drain pauses",
             bytes_sent, NCH, ranges_checked, drains);
    $display("traffic: good, broken and noise frames; idling none, sender, receiver, both");
    if (mismatches == 0) begin
      $display("tb_laser_range_frame_parser_unit OK");
    end else begin
      $display("tb_laser_range_frame_parser_unit NOT OK");
    end
    $finish;
  end

endmodule

FILE: laser_range_frame_parser_unit.f
sv/lrfp_pkg.sv
sv/lrfp_front.sv
sv/lrfp_queue.sv
sv/lrfp_back.sv
sv/laser_range_frame_parser_unit.sv
tb/tb_laser_range_frame_parser_unit.sv
